// ===== hdl/mm4_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mm4_pkg
// Shared types and constants of the 4x4 fixed-point matrix multiplier.
// ---------------------------------------------------------------------------
package mm4_pkg;

  localparam int FRAC_BITS   = 16;            // fraction bits of Q16.16
  localparam int ELEM_W      = 32;            // element width
  localparam int PROD_W      = 2 * ELEM_W;    // full product width
  localparam int ACC_W       = PROD_W + 2;    // sum of four products
  localparam int LOAD_W      = 5;             // 32 load positions
  localparam int IDX_W       = 4;             // 16 entries per matrix
  localparam int OUT_TDATA_W = 40;            // row, col, value, zero pad

  localparam logic [LOAD_W-1:0] LOAD_LAST = 5'd31;
  localparam logic [IDX_W-1:0]  ELEM_LAST = 4'd15;
  localparam logic [ELEM_W-1:0] SAT_MAX   = 32'h7FFF_FFFF;
  localparam logic [ELEM_W-1:0] SAT_MIN   = 32'h8000_0000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              wr_en;      // store in_value at wr_addr
    logic [LOAD_W-1:0] wr_addr;    // bit 4 selects the right matrix
    logic              mac_en;     // read one left/right operand pair
    logic              mac_first;  // first of four terms: restart the sum
    logic [IDX_W-1:0]  rd_a;       // left entry (row, k)
    logic [IDX_W-1:0]  rd_b;       // right entry (k, col)
    logic              final_en;   // shift, saturate and register result
    logic [IDX_W-1:0]  elem;       // product element (row, col)
  } cmd_t;

endpackage
`default_nettype wire

// ===== hdl/mm4_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mm4_ctrl
// Sequencer: load 32 elements, then run four MACs per product element.
// ---------------------------------------------------------------------------
module mm4_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  input  wire logic          in_restart,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output mm4_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_MAC   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_FINAL = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]                   state_r, state_nxt;
  logic [mm4_pkg::LOAD_W-1:0]   load_cnt_r, load_cnt_nxt;
  logic [mm4_pkg::IDX_W-1:0]    elem_r, elem_nxt;
  logic [1:0]                   k_r, k_nxt;
  logic                         drain_r, drain_nxt;
  logic [mm4_pkg::LOAD_W-1:0]   wr_addr;

  assign wr_addr = in_restart ? '0 : load_cnt_r;

  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    elem_nxt     = elem_r;
    k_nxt        = k_r;
    drain_nxt    = drain_r;
    in_tready    = 1'b0;
    out_tvalid   = 1'b0;
    cmd.wr_en     = 1'b0;
    cmd.wr_addr   = wr_addr;
    cmd.mac_en    = 1'b0;
    cmd.mac_first = (k_r == 2'd0);
    cmd.rd_a      = {elem_r[3:2], k_r};
    cmd.rd_b      = {k_r, elem_r[1:0]};
    cmd.final_en  = 1'b0;
    cmd.elem      = elem_r;
    case (state_r)
      S_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.wr_en = 1'b1;
          if (wr_addr == mm4_pkg::LOAD_LAST) begin
            load_cnt_nxt = '0;
            elem_nxt     = '0;
            k_nxt        = '0;
            state_nxt    = S_MAC;
          end else begin
            load_cnt_nxt = wr_addr + 1'b1;
          end
        end
      end
      S_MAC: begin
        cmd.mac_en = 1'b1;
        k_nxt      = k_r + 1'b1;
        if (k_r == 2'd3) begin
          drain_nxt = 1'b0;
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // wait for the multiplier and accumulator to settle
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.final_en = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (elem_r == mm4_pkg::ELEM_LAST) begin
            state_nxt = S_LOAD;
          end else begin
            elem_nxt  = elem_r + 1'b1;
            k_nxt     = '0;
            state_nxt = S_MAC;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      load_cnt_r <= '0;
      elem_r     <= '0;
      k_r        <= '0;
      drain_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      elem_r     <= elem_nxt;
      k_r        <= k_nxt;
      drain_r    <= drain_nxt;
    end
  end

  // Loading and result delivery never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output open together");

  // The 32nd element starts the first MAC run at element zero.
  a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && wr_addr == mm4_pkg::LOAD_LAST)
    |=> (state_r == S_MAC && k_r == 2'd0 && elem_r == '0 && load_cnt_r == '0))
    else $error("load completion did not start the product");

  // A result register load is always followed by an offer on the output.
  a_final_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINAL) |=> out_tvalid)
    else $error("result not offered after finalize");

  // A stalled result keeps its element index.
  a_hold_elem: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(elem_r)))
    else $error("stalled result moved");

  // After the last product element the block loads again.
  a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && elem_r == mm4_pkg::ELEM_LAST) |=> in_tready)
    else $error("no return to load after last element");

endmodule
`default_nettype wire

// ===== hdl/mm4_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mm4_dp
// Matrix stores, shared multiplier, 66-bit accumulator and saturation.
// ---------------------------------------------------------------------------
module mm4_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire mm4_pkg::cmd_t               cmd,
  input  wire logic [mm4_pkg::ELEM_W-1:0]  in_value,
  output logic [1:0]                       out_row,
  output logic [1:0]                       out_col,
  output logic [mm4_pkg::ELEM_W-1:0]       out_value,
  output logic                             out_overflow,
  output logic                             out_last
);

  logic [mm4_pkg::ELEM_W-1:0] left_mem  [16];
  logic [mm4_pkg::ELEM_W-1:0] right_mem [16];

  logic signed [mm4_pkg::ELEM_W-1:0] a_r, b_r;
  logic signed [mm4_pkg::PROD_W-1:0] prod_r;
  logic signed [mm4_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [mm4_pkg::ACC_W-1:0]  shifted;
  logic                              rd_v_r, rd_first_r;
  logic                              prod_v_r, prod_first_r;
  logic                              fits;
  logic [mm4_pkg::ELEM_W-1:0]        sat_value;

  // Stores: one write port, registered read.
  always_ff @(posedge clk) begin
    if (cmd.wr_en && !cmd.wr_addr[4]) begin
      left_mem[cmd.wr_addr[3:0]] <= in_value;
    end
    if (cmd.wr_en && cmd.wr_addr[4]) begin
      right_mem[cmd.wr_addr[3:0]] <= in_value;
    end
    if (cmd.mac_en) begin
      a_r <= left_mem[cmd.rd_a];
      b_r <= right_mem[cmd.rd_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      rd_v_r   <= cmd.mac_en;
      prod_v_r <= rd_v_r;
    end
  end

  always_comb begin
    acc_nxt = prod_first_r ? mm4_pkg::ACC_W'(prod_r)
                           : acc_r + mm4_pkg::ACC_W'(prod_r);
  end

  always_ff @(posedge clk) begin
    rd_first_r   <= cmd.mac_first;
    prod_first_r <= rd_first_r;
    if (rd_v_r) begin
      prod_r <= a_r * b_r;
    end
    if (prod_v_r) begin
      acc_r <= acc_nxt;
    end
  end

  // Arithmetic shift, then saturate when the top bits are not all sign.
  assign shifted   = acc_r >>> mm4_pkg::FRAC_BITS;
  assign fits      = (&shifted[mm4_pkg::ACC_W-1:mm4_pkg::ELEM_W-1]) ||
                     !(|shifted[mm4_pkg::ACC_W-1:mm4_pkg::ELEM_W-1]);
  assign sat_value = acc_r[mm4_pkg::ACC_W-1] ? mm4_pkg::SAT_MIN : mm4_pkg::SAT_MAX;

  always_ff @(posedge clk) begin
    if (cmd.final_en) begin
      out_row      <= cmd.elem[3:2];
      out_col      <= cmd.elem[1:0];
      out_value    <= fits ? shifted[mm4_pkg::ELEM_W-1:0] : sat_value;
      out_overflow <= !fits;
      out_last     <= (cmd.elem == mm4_pkg::ELEM_LAST);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/matrix4x4_multiply.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// matrix4x4_multiply
// 4x4 signed Q16.16 matrix product with one shared 32x32 multiplier.
// ---------------------------------------------------------------------------
// Usage:
//   Send 32 elements on the in_ channel, one per transaction: the 16 left
//   elements, then the 16 right ones, both row-major. in_tuser set marks a
//   transaction as left element zero and drops any partial load.
//   After the 32nd element the out_ channel delivers the 16 product
//   elements row-major; out_tlast marks row 3, column 3 and out_tuser flags
//   a value clamped to the 32-bit range.
// Timing:
//   Loading takes one element per cycle while in_tvalid is high. After
//   each handoff (or the last load) the next product element runs 4 MACs
//   on the shared multiplier, waits in the drain state while the product
//   and sum registers settle, passes the finalize state, then sits in the
//   output register.
// Reset and stalls:
//   rst_n (synchronous, active low) returns the block to loading with the
//   element count at zero. While out_tready is low the result holds and no
//   further MAC runs start; in_tready stays low until the last product
//   element has been taken.
// ---------------------------------------------------------------------------
module matrix4x4_multiply (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input channel
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [mm4_pkg::ELEM_W-1:0]       in_tdata,   // [31:0] elem_value
  input  wire logic                             in_tuser,   // [0] restart
  // result channel
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [mm4_pkg::OUT_TDATA_W-1:0]       out_tdata,  // [1:0] out_row,
                                                            // [3:2] out_col,
                                                            // [35:4] out_value,
                                                            // [39:36] zero
  output logic                                  out_tuser,  // [0] overflow
  output logic                                  out_tlast
);

  mm4_pkg::cmd_t              cmd;
  logic [1:0]                 res_row, res_col;
  logic [mm4_pkg::ELEM_W-1:0] res_value;

  // Sequencer: load counter, MAC steps, output handshake.
  mm4_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_restart (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // Datapath: stores, multiplier, accumulator, saturation, result register.
  mm4_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_value     (in_tdata),
    .out_row      (res_row),
    .out_col      (res_col),
    .out_value    (res_value),
    .out_overflow (out_tuser),
    .out_last     (out_tlast)
  );

  // Pack the result fields, lowest first, zero-fill to a whole byte.
  assign out_tdata = {4'b0000, res_value, res_col, res_row};

endmodule
`default_nettype wire
